// File: design/assert_macros.svh
// Assertion macros shared by the autokey decryptor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define AKSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that a condition never holds outside reset.
`define AKSD_NEVER(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);

`endif

// File: design/aksd_pkg.sv
// Package with types, codes and letter arithmetic of the autokey decryptor.
package aksd_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 32;
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned LETTERS = 26;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_DECRYPT = 2'd2;

  localparam logic [1:0] MODE_ADD      = 2'd0;
  localparam logic [1:0] MODE_SUB_KEY  = 2'd1;
  localparam logic [1:0] MODE_SUB_TEXT = 2'd2;
  localparam logic [1:0] MODE_SOLITAIRE = 2'd3;

  localparam logic [2:0] ST_DECRYPTED = 3'd0;
  localparam logic [2:0] ST_STORED    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOKEY     = 3'd3;
  localparam logic [2:0] ST_CLEARED   = 3'd4;

  typedef struct packed {
    logic [1:0]          op;
    logic [LETTER_W-1:0] letter;
  } in_word_t;

  typedef struct packed {
    logic [LETTER_W-1:0] plain_letter;
    logic [2:0]          status;
  } out_word_t;

  typedef struct packed {
    logic       we;
    logic [2:0] status;
  } ctrl_t;

  function automatic logic [LETTER_W-1:0] wrap_letter(input logic [LETTER_W-1:0] x);
    logic [LETTER_W-1:0] r;
    r = (x >= LETTER_W'(LETTERS)) ? x - LETTER_W'(LETTERS) : x;
    return r;
  endfunction

  function automatic logic [LETTER_W-1:0] combine(input logic [LETTER_W-1:0] c,
                                                  input logic [LETTER_W-1:0] k,
                                                  input logic [1:0] mode);
    logic [6:0] t;
    logic [6:0] c7;
    logic [6:0] k7;
    c7 = 7'(c);
    k7 = 7'(k);
    unique case (mode)
      MODE_ADD:      t = 7'(LETTERS) + c7 - k7;
      MODE_SUB_KEY:  t = c7 + k7;
      MODE_SUB_TEXT: t = 7'(LETTERS) + k7 - c7;
      default:       t = 7'(2 * LETTERS - 1) + c7 - k7;
    endcase
    if (t >= 7'(2 * LETTERS)) begin
      t = t - 7'(2 * LETTERS);
    end else if (t >= 7'(LETTERS)) begin
      t = t - 7'(LETTERS);
    end
    return t[LETTER_W-1:0];
  endfunction

endpackage

// File: design/aksd_ring.sv
// Key ring memory with one write port and one registered read port.
module aksd_ring import aksd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [LETTER_W-1:0] wdata_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output logic [LETTER_W-1:0] rdata_o
);

  logic [LETTER_W-1:0] mem [QUEUE_DEPTH];
  logic [LETTER_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/aksd_queue_ctrl.sv
// Head pointer and fill count of the key queue, with per-word address and status.
module aksd_queue_ctrl import aksd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_i,
  input  logic [1:0]    op_i,
  output logic [AW-1:0] raddr_o,
  output logic [AW-1:0] waddr_o,
  output ctrl_t         ctrl_o
);

  `include "assert_macros.svh"

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = $clog2(2 * QUEUE_DEPTH);

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [SW-1:0] sum;
  logic [AW-1:0] head_inc;
  logic          full;
  logic          empty;

  assign sum      = SW'(head_q) + SW'(fill_q);
  assign waddr_o  = (sum >= SW'(QUEUE_DEPTH)) ? AW'(sum - SW'(QUEUE_DEPTH)) : AW'(sum);
  assign head_inc = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign full     = (fill_q == CW'(QUEUE_DEPTH));
  assign empty    = (fill_q == '0);
  assign raddr_o  = head_q;

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    ctrl_o = '{we: 1'b0, status: ST_CLEARED};
    unique case (op_i)
      OP_LOAD: begin
        if (full) begin
          ctrl_o.status = ST_FULL;
        end else begin
          ctrl_o = '{we: 1'b1, status: ST_STORED};
          fill_d = fill_q + 1'b1;
        end
      end
      OP_DECRYPT: begin
        if (empty) begin
          ctrl_o.status = ST_NOKEY;
        end else begin
          ctrl_o = '{we: 1'b1, status: ST_DECRYPTED};
          head_d = head_inc;
        end
      end
      default: begin
        head_d = '0;
        fill_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else if (acc_i) begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  `AKSD_ASSERT(a_decrypt_keeps_fill, acc_i && op_i == OP_DECRYPT && !empty |=> fill_q == $past(fill_q), "decrypt changed the fill count")
  `AKSD_ASSERT(a_idle_holds_head, !acc_i |=> $stable(head_q) && $stable(fill_q), "queue pointers moved without a word")
  `AKSD_NEVER(a_fill_bound, fill_q > CW'(QUEUE_DEPTH), "fill count above queue depth")

endmodule

// File: design/autokey_stream_decrypt.sv
// A result word is registered in the key read stage and then in the output register after its input word
// is accepted; an output stall holds it in the key read stage.
// Throughput: one word per cycle while the output is not stalled, set by the key ring read-modify-write;
// a key read that hits the previous word's write is forwarded.
// Reset clears the queue pointers, the combine mode and the pipeline valids;
// the key ring contents are undefined until written.
// Top level of the autokey stream decryptor.
module autokey_stream_decrypt import aksd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i,
  input  logic       in_valid_i,
  input  in_word_t   in_word_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  output out_word_t  out_word_o,
  input  logic       out_stall_i
);

  `include "assert_macros.svh"

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [1:0]          mode_q;
  logic                in_acc;
  logic                s1_fire;
  logic                s1_valid_q;
  logic                s1_we_q;
  logic [2:0]          s1_status_q;
  logic [AW-1:0]       s1_waddr_q;
  logic [LETTER_W-1:0] s1_letter_q;
  logic                fwd_q;
  logic [LETTER_W-1:0] fwd_data_q;
  logic                out_valid_q;
  out_word_t           out_word_q;
  logic [AW-1:0]       raddr;
  logic [AW-1:0]       waddr;
  ctrl_t               ctrl;
  logic [LETTER_W-1:0] rdata;
  logic [LETTER_W-1:0] key;
  logic [LETTER_W-1:0] plain;
  logic [LETTER_W-1:0] wdata;
  logic                decrypted;

  assign cfg_ready_o = 1'b1;
  assign s1_fire     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !s1_fire;
  assign in_acc      = in_valid_i && !in_stall_o;

  aksd_queue_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .AW         (AW)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (in_acc),
    .op_i   (in_word_i.op),
    .raddr_o(raddr),
    .waddr_o(waddr),
    .ctrl_o (ctrl)
  );

  aksd_ring #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .AW         (AW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (s1_fire && s1_we_q),
    .waddr_i(s1_waddr_q),
    .wdata_i(wdata),
    .re_i   (in_acc),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign key       = fwd_q ? fwd_data_q : rdata;
  assign plain     = combine(s1_letter_q, key, mode_q);
  assign decrypted = (s1_status_q == ST_DECRYPTED);
  assign wdata     = decrypted ? plain : s1_letter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ADD;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_fire && s1_we_q && (s1_waddr_q == raddr);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_we_q     <= ctrl.we;
      s1_status_q <= ctrl.status;
      s1_waddr_q  <= waddr;
      s1_letter_q <= wrap_letter(in_word_i.letter);
      fwd_data_q  <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_word_q.plain_letter <= decrypted ? plain : '0;
      out_word_q.status       <= s1_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `AKSD_ASSERT(a_fire_gives_word, s1_fire |=> out_valid_o, "stage word did not reach output")
  `AKSD_ASSERT(a_busy_stalls, s1_valid_q && !s1_fire |-> in_stall_o, "input taken while stage blocked")
  `AKSD_NEVER(a_plain_range, out_valid_o && out_word_o.plain_letter > LETTER_W'(LETTERS - 1), "plain letter out of range")

endmodule

// File: sim/autokey_stream_decrypt_checker.sv
// Channel monitor, letter-queue predictor and result comparator for the autokey decryptor.
`timescale 1ns / 1ps

module autokey_stream_decrypt_checker import aksd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [1:0] cfg_data_i,
  input  logic       in_valid_i,
  input  in_word_t   in_word_i,
  input  logic       in_stall_i,
  input  logic       out_valid_i,
  input  out_word_t  out_word_i,
  input  logic       out_stall_i,
  output int         err_count_o,
  output int         pending_o
);

  logic [LETTER_W-1:0] key_ring [QUEUE_DEPTH];
  int unsigned         head_ptr;
  int unsigned         fill;
  logic [1:0]          mode;
  out_word_t           decoded_q [$];
  int                  errs;

  function automatic out_word_t decode_word(input in_word_t w);
    int        c;
    int        k;
    int        p;
    out_word_t r;
    c = int'(w.letter) % int'(LETTERS);
    p = 0;
    r.plain_letter = '0;
    case (w.op)
      OP_LOAD: begin
        if (fill >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          key_ring[(head_ptr + fill) % QUEUE_DEPTH] = LETTER_W'(c);
          fill++;
          r.status = ST_STORED;
        end
      end
      OP_DECRYPT: begin
        if (fill == 0) begin
          r.status = ST_NOKEY;
        end else begin
          k = int'(key_ring[head_ptr]);
          case (mode)
            MODE_ADD:      p = c - k;
            MODE_SUB_KEY:  p = c + k;
            MODE_SUB_TEXT: p = k - c;
            default:       p = c - k - 1;
          endcase
          p = (p + 2 * int'(LETTERS)) % int'(LETTERS);
          head_ptr = (head_ptr + 1) % QUEUE_DEPTH;
          key_ring[(head_ptr + fill - 1) % QUEUE_DEPTH] = LETTER_W'(p);
          r.plain_letter = LETTER_W'(p);
          r.status = ST_DECRYPTED;
        end
      end
      default: begin
        head_ptr = 0;
        fill = 0;
        r.status = ST_CLEARED;
      end
    endcase
    return r;
  endfunction

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (decoded_q.size() == 0) begin
      $error("result word with no expected word waiting: plain_letter %0d, status %0d",
             got.plain_letter, got.status);
      errs++;
    end else begin
      want = decoded_q.pop_front();
      if (got.plain_letter !== want.plain_letter) begin
        $error("plain_letter: expected %0d, actual %0d", want.plain_letter, got.plain_letter);
        errs++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errs++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_ptr = 0;
      fill = 0;
      mode = MODE_ADD;
      decoded_q.delete();
      errs = 0;
      err_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        check_word(out_word_i);
      end
      if (in_valid_i && !in_stall_i) begin
        decoded_q.push_back(decode_word(in_word_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        mode = cfg_data_i;
      end
      err_count_o <= errs;
      pending_o <= decoded_q.size();
    end
  end

endmodule

// File: sim/autokey_stream_decrypt_tb.sv
// Stimulus, clock, reset and final verdict for the autokey decryptor testbench.
`timescale 1ns / 1ps

module autokey_stream_decrypt_tb import aksd_pkg::*;;

  localparam logic [1:0] OP_CLEAR_ALIAS = 2'd3;
  localparam int         LIMIT = 200000;
  localparam int         PHASES = 8;
  localparam int         PHASE_WORDS = 70;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0] cfg_data = MODE_ADD;
  logic      in_valid = 1'b0;
  in_word_t  in_word = '0;
  logic      in_stall;
  logic      out_valid;
  out_word_t out_word;
  logic      out_stall = 1'b0;

  int        err_count;
  int        pending;
  int        words_sent = 0;
  int        cycles = 0;
  bit        calm = 1'b1;

  autokey_stream_decrypt dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_word_i  (in_word),
    .in_stall_o (in_stall),
    .out_valid_o(out_valid),
    .out_word_o (out_word),
    .out_stall_i(out_stall)
  );

  autokey_stream_decrypt_checker checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_word_i  (in_word),
    .in_stall_i (in_stall),
    .out_valid_i(out_valid),
    .out_word_i (out_word),
    .out_stall_i(out_stall),
    .err_count_o(err_count),
    .pending_o  (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("autokey_stream_decrypt_tb: FAIL");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) begin
      return 0;
    end else if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 24);
  endfunction

  function automatic logic [LETTER_W-1:0] rand_letter();
    if ($urandom_range(0, 9) == 0) begin
      return LETTER_W'($urandom_range(26, 31));
    end
    return LETTER_W'($urandom_range(0, 25));
  endfunction

  task automatic send_word(input logic [1:0] w_op, input logic [LETTER_W-1:0] w_letter);
    int unsigned gap;
    in_word_t    w;
    gap = pick_gap();
    w.op = w_op;
    w.letter = w_letter;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_sequence();
    int unsigned r;
    int unsigned s;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      send_word(($urandom_range(0, 7) == 0) ? OP_CLEAR_ALIAS : OP_CLEAR,
                LETTER_W'($urandom_range(0, 31)));
      s = $urandom_range(0, 9);
      if (s < 5) begin
        n = $urandom_range(1, 4);
      end else if (s < 8) begin
        n = $urandom_range(5, 12);
      end else if (s < 9) begin
        n = $urandom_range(13, 32);
      end else begin
        n = $urandom_range(30, 36);
      end
      repeat (n) send_word(OP_LOAD, rand_letter());
      n = $urandom_range(1, 12);
      repeat (n) begin
        if ($urandom_range(0, 19) == 0) begin
          send_word(OP_LOAD, rand_letter());
        end
        send_word(OP_DECRYPT, rand_letter());
      end
    end else if (r < 90) begin
      n = $urandom_range(1, 6);
      repeat (n) send_word(2'($urandom_range(0, 3)), LETTER_W'($urandom_range(0, 31)));
    end else begin
      send_word(OP_CLEAR, LETTER_W'($urandom_range(0, 31)));
      n = $urandom_range(1, 3);
      repeat (n) send_word(OP_DECRYPT, rand_letter());
    end
  endtask

  initial begin
    int unsigned n;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  initial begin
    logic [1:0] m;
    int         target;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(OP_DECRYPT, 5'd31);
    send_word(OP_CLEAR_ALIAS, 5'd31);
    send_word(OP_LOAD, 5'd0);
    send_word(OP_LOAD, 5'd25);
    send_word(OP_LOAD, 5'd31);
    send_word(OP_DECRYPT, 5'd0);
    send_word(OP_DECRYPT, 5'd25);
    send_word(OP_DECRYPT, 5'd26);
    send_word(OP_DECRYPT, 5'd31);
    send_word(OP_LOAD, 5'd26);
    send_word(OP_CLEAR, 5'd0);
    send_word(OP_DECRYPT, 5'd13);
    send_word(OP_LOAD, 5'd7);
    send_word(OP_DECRYPT, 5'd0);
    send_word(OP_DECRYPT, 5'd25);
    send_word(OP_DECRYPT, 5'd12);
    send_word(OP_DECRYPT, 5'd31);
    send_word(OP_DECRYPT, 5'd3);
    send_word(OP_LOAD, 5'd1);
    send_word(OP_DECRYPT, 5'd9);
    send_word(OP_DECRYPT, 5'd30);
    send_word(OP_CLEAR, 5'd31);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       m = MODE_SOLITAIRE;
        1:       m = MODE_SUB_KEY;
        2:       m = MODE_SUB_TEXT;
        3:       m = MODE_ADD;
        default: m = 2'($urandom_range(0, 3));
      endcase
      calm = (phase == 2 || phase == 5);
      write_mode(m);
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        run_sequence();
      end
    end

    drain();
    if (err_count == 0) begin
      $display("autokey_stream_decrypt_tb: PASS");
    end else begin
      $display("autokey_stream_decrypt_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: autokey_stream_decrypt.f
+incdir+design
design/aksd_pkg.sv
design/aksd_ring.sv
design/aksd_queue_ctrl.sv
design/autokey_stream_decrypt.sv
sim/autokey_stream_decrypt_checker.sv
sim/autokey_stream_decrypt_tb.sv
